@@ rtl/core/yield_rate_reducer_top_assert.svh @@
// Assertion macros for the yield rate reducer
`ifndef YIELD_RATE_REDUCER_TOP_ASSERT_SVH
`define YIELD_RATE_REDUCER_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define YRR_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define YRR_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) pre |=> post) else $error(msg);
`else
`define YRR_ASSERT(lbl, clk, rst_n, prop, msg)
`define YRR_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)
`endif
`endif

@@ rtl/core/yrr_pkg.sv @@
`timescale 1ns / 1ps
package yrr_pkg;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_YIELD_ENABLE = 3'd0,
        CFG_POLICY       = 3'd1,
        CFG_FIXED_RATE   = 3'd2,
        CFG_STAIR_PERIOD = 3'd3,
        CFG_STAIR_RATIO  = 3'd4,
        CFG_STAIR_FLOOR  = 3'd5,
        CFG_DECAY_RATIO  = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        POL_FIXED = 2'd0,
        POL_STAIR = 2'd1,
        POL_DECAY = 2'd2,
        POL_NONE  = 2'd3
    } t_policy;

    localparam logic [63:0] RST_FIXED_RATE       = 64'd10000000;
    localparam logic [15:0] RST_STAIR_PERIOD     = 16'd2000;
    localparam logic [31:0] RST_STAIR_RATIO_Q32  = 32'd3865470566;
    localparam logic [31:0] RST_STAIR_FLOOR_Q32  = 32'd42950;
    localparam logic [31:0] RST_DECAY_RATIO_Q32  = 32'd4290674474;

endpackage

@@ rtl/core/yrr_in_if.sv @@
`timescale 1ns / 1ps
interface yrr_in_if #(
    parameter int RATE_BITS = 40
);
    logic                 valid;
    logic                 ready;
    logic                 func;
    logic [31:0]          tag;
    logic [RATE_BITS-1:0] model_rate;

    modport source (output valid, output func, output tag, output model_rate, input ready);
    modport sink   (input valid, input func, input tag, input model_rate, output ready);
endinterface

@@ rtl/core/yrr_out_if.sv @@
`timescale 1ns / 1ps
interface yrr_out_if #(
    parameter int RATE_BITS = 40
);
    logic                 valid;
    logic                 ready;
    logic [31:0]          tag_out;
    logic [RATE_BITS-1:0] rate_out;
    logic                 reduced;

    modport source (output valid, output tag_out, output rate_out, output reduced, input ready);
    modport sink   (input valid, input tag_out, input rate_out, input reduced, output ready);
endinterface

@@ rtl/core/yield_rate_reducer_top.sv @@
// Yield rate reducer: takes one beat per clock on i_item unless back-pressured, either an
// enter-yield event (no result) or a rate proposal (one result on o_result, tag echoed,
// from the result register). The sustained rate is one beat per cycle, set by the single
// 32 x 32 multiply per factor that updates the stairway and decay factors between their
// registers; the rate products behind that run in two stages of split partial products.
// Each stage holds its beat under back-pressure and takes a new one as soon as it empties.
// Write the configuration only while no proposal is in flight.
`timescale 1ns / 1ps
`include "yield_rate_reducer_top_assert.svh"
module yield_rate_reducer_top
    import yrr_pkg::*;
#(
    parameter int RATE_BITS = 40,
    parameter int FRAC_BITS = 32
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_we,
    input  logic [CFG_IDX_W-1:0]                      i_cfg_idx,
    input  logic [((RATE_BITS > 32) ? RATE_BITS : 32)-1:0] i_cfg_data,
    yrr_in_if.sink                                    i_item,
    yrr_out_if.source                                 o_result
);

    localparam int LO_W   = (RATE_BITS + 1) / 2;
    localparam int HI_W   = RATE_BITS - LO_W;
    localparam int PROD_W = RATE_BITS + FRAC_BITS;

    localparam logic [RATE_BITS-1:0] RST_FIXED = RATE_BITS'(RST_FIXED_RATE);
    localparam logic [FRAC_BITS-1:0] RST_SR    =
        FRAC_BITS'(RST_STAIR_RATIO_Q32 >> (32 - FRAC_BITS));
    localparam logic [FRAC_BITS-1:0] RST_SF    =
        FRAC_BITS'(RST_STAIR_FLOOR_Q32 >> (32 - FRAC_BITS));
    localparam logic [FRAC_BITS-1:0] RST_DR    =
        FRAC_BITS'(RST_DECAY_RATIO_Q32 >> (32 - FRAC_BITS));

    // configuration
    logic                 r_cfg_enable;
    t_policy              r_policy;
    logic [RATE_BITS-1:0] r_fixed_rate;
    logic [15:0]          r_period;
    logic [FRAC_BITS-1:0] r_stair_ratio;
    logic [FRAC_BITS-1:0] r_stair_floor;
    logic [FRAC_BITS-1:0] r_decay_ratio;

    // yield state; a factor is either exactly one or held in its fraction bits
    logic                 r_yield_active, n_yield_active;
    logic                 r_latched, n_latched;
    logic [RATE_BITS-1:0] r_init, n_init;
    logic [15:0]          r_pc, n_pc;
    logic [FRAC_BITS-1:0] r_sf, n_sf;
    logic                 r_sf_one, n_sf_one;
    logic [FRAC_BITS-1:0] r_df, n_df;
    logic                 r_df_one, n_df_one;

    // stage 1: input register
    logic                 r_s1_v;
    logic                 r_s1_func;
    logic [31:0]          r_s1_tag;
    logic [RATE_BITS-1:0] r_s1_rate;

    // stage 2: operand register
    logic                 r_s2_v;
    logic [31:0]          r_s2_tag;
    logic [RATE_BITS-1:0] r_s2_rate, n_s2_rate;
    logic [FRAC_BITS-1:0] r_s2_fac, n_s2_fac;
    logic                 r_s2_mul, n_s2_mul;
    logic                 r_s2_red, n_s2_red;

    // stage 3: partial products
    logic                      r_s3_v;
    logic [31:0]               r_s3_tag;
    logic [RATE_BITS-1:0]      r_s3_rate;
    logic                      r_s3_mul;
    logic                      r_s3_red;
    logic [LO_W+FRAC_BITS-1:0] r_s3_plo;
    logic [HI_W+FRAC_BITS-1:0] r_s3_phi;

    // stage 4: result register
    logic                 r_o_valid;
    logic [31:0]          r_o_tag;
    logic [RATE_BITS-1:0] r_o_rate;
    logic                 r_o_red;

    logic en1, en2, en3, en4;
    logic w_adv1, w_yield;
    logic [RATE_BITS-1:0]   w_eff_init;
    logic [15:0]            w_eff_pc, w_eff_period;
    logic [16:0]            w_pc_inc;
    logic [2*FRAC_BITS-1:0] w_sf_prod, w_df_prod;
    logic [FRAC_BITS-1:0]   w_sf_mul, w_df_mul;
    logic                   w_stair_step;
    logic [LO_W+FRAC_BITS-1:0] w_plo;
    logic [HI_W+FRAC_BITS-1:0] w_phi;
    logic [PROD_W-1:0]         w_sum;
    logic [RATE_BITS-1:0]      w_out_rate;

    // handshake: each stage moves when the one after it can take the beat
    assign en4 = !r_o_valid || o_result.ready;
    assign en3 = !r_s3_v || en4;
    assign en2 = !r_s2_v || en3;
    assign en1 = !r_s1_v || en2;
    assign i_item.ready = en1;

    assign o_result.valid    = r_o_valid;
    assign o_result.tag_out  = r_o_tag;
    assign o_result.rate_out = r_o_rate;
    assign o_result.reduced  = r_o_red;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_enable  <= 1'b1;
            r_policy      <= POL_FIXED;
            r_fixed_rate  <= RST_FIXED;
            r_period      <= RST_STAIR_PERIOD;
            r_stair_ratio <= RST_SR;
            r_stair_floor <= RST_SF;
            r_decay_ratio <= RST_DR;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_YIELD_ENABLE: r_cfg_enable  <= i_cfg_data[0];
                CFG_POLICY:       r_policy      <= t_policy'(i_cfg_data[1:0]);
                CFG_FIXED_RATE:   r_fixed_rate  <= i_cfg_data[RATE_BITS-1:0];
                CFG_STAIR_PERIOD: r_period      <= i_cfg_data[15:0];
                CFG_STAIR_RATIO:  r_stair_ratio <= i_cfg_data[FRAC_BITS-1:0];
                CFG_STAIR_FLOOR:  r_stair_floor <= i_cfg_data[FRAC_BITS-1:0];
                CFG_DECAY_RATIO:  r_decay_ratio <= i_cfg_data[FRAC_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign w_adv1       = r_s1_v && en2;
    assign w_yield      = r_yield_active && r_cfg_enable;
    assign w_eff_init   = r_latched ? r_init : r_s1_rate;
    assign w_eff_pc     = r_latched ? r_pc : 16'd0;
    assign w_eff_period = (r_period == 16'd0) ? 16'd1 : r_period;
    assign w_pc_inc     = {1'b0, w_eff_pc} + 17'd1;
    assign w_sf_prod    = r_sf * r_stair_ratio;
    assign w_df_prod    = r_df * r_decay_ratio;
    assign w_sf_mul     = r_sf_one ? r_stair_ratio : w_sf_prod[2*FRAC_BITS-1:FRAC_BITS];
    assign w_df_mul     = r_df_one ? r_decay_ratio : w_df_prod[2*FRAC_BITS-1:FRAC_BITS];
    assign w_stair_step = (r_policy == POL_STAIR) && (w_eff_pc == 16'd0)
                          && (r_sf_one || (r_sf >= r_stair_floor));

    always_comb begin
        n_yield_active = r_yield_active;
        n_latched      = r_latched;
        n_init         = r_init;
        n_pc           = r_pc;
        n_sf           = r_sf;
        n_sf_one       = r_sf_one;
        n_df           = r_df;
        n_df_one       = r_df_one;
        if (w_adv1) begin
            if (r_s1_func) begin
                n_yield_active = 1'b1;
            end else if (w_yield) begin
                n_latched = 1'b1;
                n_init    = w_eff_init;
                n_pc      = (w_pc_inc >= {1'b0, w_eff_period}) ? 16'd0 : w_pc_inc[15:0];
                n_df      = w_df_mul;
                n_df_one  = 1'b0;
                if (w_stair_step) begin
                    n_sf     = w_sf_mul;
                    n_sf_one = 1'b0;
                end
            end
        end
    end

    always_comb begin
        n_s2_rate = r_s1_rate;
        n_s2_fac  = r_sf;
        n_s2_mul  = 1'b0;
        n_s2_red  = 1'b0;
        if (w_yield) begin
            case (r_policy)
                POL_FIXED: begin
                    n_s2_rate = r_fixed_rate;
                    n_s2_red  = 1'b1;
                end
                POL_STAIR: begin
                    n_s2_rate = w_eff_init;
                    n_s2_fac  = r_sf;
                    n_s2_mul  = !r_sf_one;
                    n_s2_red  = 1'b1;
                end
                POL_DECAY: begin
                    n_s2_rate = w_eff_init;
                    n_s2_fac  = r_df;
                    n_s2_mul  = !r_df_one;
                    n_s2_red  = 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign w_plo      = r_s2_rate[LO_W-1:0] * r_s2_fac;
    assign w_phi      = r_s2_rate[RATE_BITS-1:LO_W] * r_s2_fac;
    assign w_sum      = {r_s3_phi, {LO_W{1'b0}}} + PROD_W'(r_s3_plo);
    assign w_out_rate = r_s3_mul ? w_sum[PROD_W-1:FRAC_BITS] : r_s3_rate;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yield_active <= 1'b0;
            r_latched      <= 1'b0;
            r_init         <= '0;
            r_pc           <= '0;
            r_sf           <= '0;
            r_sf_one       <= 1'b1;
            r_df           <= '0;
            r_df_one       <= 1'b1;
            r_s1_v         <= 1'b0;
            r_s2_v         <= 1'b0;
            r_s3_v         <= 1'b0;
            r_o_valid      <= 1'b0;
        end else begin
            r_yield_active <= n_yield_active;
            r_latched      <= n_latched;
            r_init         <= n_init;
            r_pc           <= n_pc;
            r_sf           <= n_sf;
            r_sf_one       <= n_sf_one;
            r_df           <= n_df;
            r_df_one       <= n_df_one;
            if (en1) begin
                r_s1_v <= i_item.valid;
            end
            if (en2) begin
                r_s2_v <= r_s1_v && !r_s1_func;
            end
            if (en3) begin
                r_s3_v <= r_s2_v;
            end
            if (en4) begin
                r_o_valid <= r_s3_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1 && i_item.valid) begin
            r_s1_func <= i_item.func;
            r_s1_tag  <= i_item.tag;
            r_s1_rate <= i_item.model_rate;
        end
        if (w_adv1) begin
            r_s2_tag  <= r_s1_tag;
            r_s2_rate <= n_s2_rate;
            r_s2_fac  <= n_s2_fac;
            r_s2_mul  <= n_s2_mul;
            r_s2_red  <= n_s2_red;
        end
        if (en3 && r_s2_v) begin
            r_s3_tag  <= r_s2_tag;
            r_s3_rate <= r_s2_rate;
            r_s3_mul  <= r_s2_mul;
            r_s3_red  <= r_s2_red;
            r_s3_plo  <= w_plo;
            r_s3_phi  <= w_phi;
        end
        if (en4 && r_s3_v) begin
            r_o_tag  <= r_s3_tag;
            r_o_rate <= w_out_rate;
            r_o_red  <= r_s3_red;
        end
    end

    `YRR_ASSERT(a_red_needs_yield, i_clk, i_rst_n, (r_o_valid && r_o_red) |-> r_yield_active, "reduced beat outside yield mode")
    `YRR_ASSERT(a_latch_needs_yield, i_clk, i_rst_n, r_latched |-> r_yield_active, "rate latched outside yield mode")
    `YRR_ASSERT_NEXT(a_sf_stays_reduced, i_clk, i_rst_n, !r_sf_one, !r_sf_one, "stairway factor returned to one")
    `YRR_ASSERT(a_fixed_rate, i_clk, i_rst_n, (r_o_valid && r_o_red && (r_policy == POL_FIXED)) |-> (r_o_rate == r_fixed_rate), "fixed policy rate mismatch")

endmodule

@@ tb/sv/tb_yield_rate_reducer_top.sv @@
`timescale 1ns / 1ps
module tb_yield_rate_reducer_top;
    import yrr_pkg::*;

    localparam int RATE_W     = 40;
    localparam int FRAC_W     = 32;
    localparam int CFG_W      = 40;
    localparam int DRAIN_WAIT = 8;
    localparam int HOLD_LEN   = 300;
    localparam int STUCK_MAX  = 5000;

    localparam logic EV_PROPOSAL    = 1'b0;
    localparam logic EV_ENTER_YIELD = 1'b1;

    localparam logic [RATE_W-1:0] RATE_MAX = '1;
    localparam logic [31:0]       Q32_MAX  = 32'hFFFF_FFFF;
    localparam logic [32:0]       Q32_ONE  = 33'h1_0000_0000;

    typedef struct {
        logic              func;
        logic [31:0]       tag;
        logic [RATE_W-1:0] rate;
    } t_rate_event;

    typedef struct {
        logic [31:0]       tag;
        logic [RATE_W-1:0] rate;
        logic              reduced;
    } t_rate_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [CFG_W-1:0]     cfg_data;

    yrr_in_if  #(.RATE_BITS(RATE_W)) item_if ();
    yrr_out_if #(.RATE_BITS(RATE_W)) result_if ();

    yield_rate_reducer_top #(
        .RATE_BITS(RATE_W),
        .FRAC_BITS(FRAC_W)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (cfg_we),
        .i_cfg_idx (cfg_idx),
        .i_cfg_data(cfg_data),
        .i_item    (item_if),
        .o_result  (result_if)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // register shadow
    logic              cfg_enable;
    t_policy           cfg_policy;
    logic [RATE_W-1:0] cfg_fixed_rate;
    logic [15:0]       cfg_period;
    logic [31:0]       cfg_stair_ratio;
    logic [31:0]       cfg_floor;
    logic [31:0]       cfg_decay_ratio;

    // reducer state
    logic              yield_on;
    logic              latched;
    logic [RATE_W-1:0] base_rate;
    logic [15:0]       step_cnt;
    logic [32:0]       stair_fac;
    logic [32:0]       decay_fac;

    t_rate_event  beats_to_send[$];
    t_rate_result rates_due[$];
    t_rate_result want_result;

    int src_idle_pct;
    int sink_stall_pct;
    int hold_epoch;
    int hold_seen;
    int hold_left;
    int stuck_cycles;
    int n_queued;
    int n_accepted;
    int n_enters;
    int n_results;
    int n_errors;
    int n_by_policy[4];

    function automatic logic [63:0] fx_mul(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        return p[95:32];
    endfunction

    task automatic predict_beat(input t_rate_event ev);
        t_rate_result r;
        logic [63:0]  prod;
        logic [16:0]  period;
        logic [16:0]  next_cnt;
        if (ev.func == EV_ENTER_YIELD) begin
            yield_on = 1'b1;
            n_enters++;
            return;
        end
        r.tag     = ev.tag;
        r.rate    = ev.rate;
        r.reduced = 1'b0;
        if (yield_on && cfg_enable) begin
            if (!latched) begin
                base_rate = ev.rate;
                step_cnt  = '0;
                latched   = 1'b1;
            end
            r.reduced = 1'b1;
            n_by_policy[cfg_policy]++;
            case (cfg_policy)
                POL_FIXED: r.rate = cfg_fixed_rate;
                POL_STAIR: begin
                    prod   = fx_mul(64'(base_rate), 64'(stair_fac));
                    r.rate = prod[RATE_W-1:0];
                    if (step_cnt == 16'd0 && stair_fac >= 33'(cfg_floor)) begin
                        prod      = fx_mul(64'(stair_fac), 64'(cfg_stair_ratio));
                        stair_fac = prod[32:0];
                    end
                end
                POL_DECAY: begin
                    prod   = fx_mul(64'(base_rate), 64'(decay_fac));
                    r.rate = prod[RATE_W-1:0];
                end
                default: begin
                    r.rate    = ev.rate;
                    r.reduced = 1'b0;
                end
            endcase
            prod      = fx_mul(64'(decay_fac), 64'(cfg_decay_ratio));
            decay_fac = prod[32:0];
            period    = (cfg_period == 16'd0) ? 17'd1 : {1'b0, cfg_period};
            next_cnt  = {1'b0, step_cnt} + 17'd1;
            step_cnt  = (next_cnt >= period) ? 16'd0 : next_cnt[15:0];
        end
        rates_due.push_back(r);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] val);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        case (idx)
            CFG_YIELD_ENABLE: cfg_enable      = val[0];
            CFG_POLICY:       cfg_policy      = t_policy'(val[1:0]);
            CFG_FIXED_RATE:   cfg_fixed_rate  = val[RATE_W-1:0];
            CFG_STAIR_PERIOD: cfg_period      = val[15:0];
            CFG_STAIR_RATIO:  cfg_stair_ratio = val[31:0];
            CFG_STAIR_FLOOR:  cfg_floor       = val[31:0];
            CFG_DECAY_RATIO:  cfg_decay_ratio = val[31:0];
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic add_beat(input logic func, input logic [31:0] tag,
                            input logic [RATE_W-1:0] rate);
        t_rate_event ev;
        ev.func = func;
        ev.tag  = tag;
        ev.rate = rate;
        beats_to_send.push_back(ev);
        n_queued++;
    endtask

    task automatic add_random_beats(input int count);
        logic [RATE_W-1:0] rate;
        repeat (count) begin
            case ($urandom_range(7))
                0:       rate = '0;
                1:       rate = RATE_MAX;
                2:       rate = RATE_W'($urandom_range(100_000_000));
                default: rate = {8'($urandom), 32'($urandom)};
            endcase
            add_beat(($urandom_range(19) == 0) ? EV_ENTER_YIELD : EV_PROPOSAL, $urandom, rate);
        end
    endtask

    task automatic settle();
        while (n_accepted != n_queued || rates_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic shuffle_config();
        write_reg(CFG_YIELD_ENABLE, CFG_W'($urandom_range(4) != 0));
        write_reg(CFG_POLICY, CFG_W'($urandom_range(3)));
        write_reg(CFG_FIXED_RATE, {8'($urandom), 32'($urandom)});
        write_reg(CFG_STAIR_PERIOD,
                  ($urandom_range(5) == 0) ? CFG_W'(16'hFFFF) : CFG_W'($urandom_range(1, 12)));
        write_reg(CFG_STAIR_RATIO, CFG_W'({2'b11, 30'($urandom)}));
        write_reg(CFG_STAIR_FLOOR, CFG_W'($urandom_range(32'h4000_0000)));
        write_reg(CFG_DECAY_RATIO, CFG_W'({8'hFF, 24'($urandom)}));
    endtask

    task automatic run_phase(input int src_pct, input int snk_pct, input int count);
        src_idle_pct   = src_pct;
        sink_stall_pct = snk_pct;
        shuffle_config();
        add_random_beats(count);
        settle();
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            item_if.valid <= 1'b0;
        end else begin
            if (item_if.valid && item_if.ready) begin
                predict_beat(t_rate_event'{item_if.func, item_if.tag, item_if.model_rate});
                n_accepted++;
            end
            if (!item_if.valid || item_if.ready) begin
                if (beats_to_send.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
                    t_rate_event ev;
                    ev = beats_to_send.pop_front();
                    item_if.valid      <= 1'b1;
                    item_if.func       <= ev.func;
                    item_if.tag        <= ev.tag;
                    item_if.model_rate <= ev.rate;
                end else begin
                    item_if.valid <= 1'b0;
                end
            end
        end
    end

    // receiver, with a long hold-off on request
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_if.ready <= 1'b0;
        end else if (hold_epoch != hold_seen) begin
            hold_seen       <= hold_epoch;
            hold_left       <= HOLD_LEN;
            result_if.ready <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left       <= hold_left - 1;
            result_if.ready <= 1'b0;
        end else begin
            result_if.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && result_if.valid && result_if.ready) begin
            n_results++;
            if (rates_due.size() == 0) begin
                $error("unexpected result beat: tag_out %0h rate_out %0h reduced %0b",
                       result_if.tag_out, result_if.rate_out, result_if.reduced);
                n_errors++;
            end else begin
                want_result = rates_due.pop_front();
                if (result_if.tag_out !== want_result.tag) begin
                    $error("tag_out: expected %0h, got %0h", want_result.tag, result_if.tag_out);
                    n_errors++;
                end
                if (result_if.rate_out !== want_result.rate) begin
                    $error("rate_out: expected %0h, got %0h",
                           want_result.rate, result_if.rate_out);
                    n_errors++;
                end
                if (result_if.reduced !== want_result.reduced) begin
                    $error("reduced: expected %0b, got %0b",
                           want_result.reduced, result_if.reduced);
                    n_errors++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) || (result_if.valid && result_if.ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_MAX) begin
            $display("tb: failure");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        i_rst_n            = 1'b0;
        cfg_we             = 1'b0;
        cfg_idx            = '0;
        cfg_data           = '0;
        item_if.valid      = 1'b0;
        item_if.func       = EV_PROPOSAL;
        item_if.tag        = '0;
        item_if.model_rate = '0;
        result_if.ready    = 1'b0;
        src_idle_pct       = 0;
        sink_stall_pct     = 0;
        hold_epoch         = 0;
        hold_seen          = 0;
        hold_left          = 0;
        stuck_cycles       = 0;
        n_queued           = 0;
        n_accepted         = 0;
        n_enters           = 0;
        n_results          = 0;
        n_errors           = 0;
        n_by_policy        = '{0, 0, 0, 0};

        cfg_enable      = 1'b1;
        cfg_policy      = POL_FIXED;
        cfg_fixed_rate  = RATE_W'(RST_FIXED_RATE);
        cfg_period      = RST_STAIR_PERIOD;
        cfg_stair_ratio = RST_STAIR_RATIO_Q32;
        cfg_floor       = RST_STAIR_FLOOR_Q32;
        cfg_decay_ratio = RST_DECAY_RATIO_Q32;
        yield_on        = 1'b0;
        latched         = 1'b0;
        base_rate       = '0;
        step_cnt        = '0;
        stair_fac       = Q32_ONE;
        decay_fac       = Q32_ONE;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pass through before yield, then fixed policy from reset values
        add_beat(EV_PROPOSAL, 32'h0, '0);
        add_beat(EV_PROPOSAL, 32'hFFFF_FFFF, RATE_MAX);
        add_beat(EV_PROPOSAL, 32'h5555_5555, 40'hAA_AAAA_AAAA);
        add_beat(EV_ENTER_YIELD, 32'h1234_5678, 40'h12_3456_789A);
        add_beat(EV_ENTER_YIELD, 32'hAAAA_AAAA, 40'h55_5555_5555);
        add_beat(EV_PROPOSAL, 32'h1, RATE_MAX);
        add_beat(EV_PROPOSAL, 32'h2, '0);
        settle();

        // stairway, period of zero, floor at its top
        write_reg(CFG_POLICY, CFG_W'(POL_STAIR));
        write_reg(CFG_STAIR_PERIOD, '0);
        write_reg(CFG_STAIR_FLOOR, CFG_W'(Q32_MAX));
        repeat (3) add_beat(EV_PROPOSAL, $urandom, {8'($urandom), 32'($urandom)});
        settle();

        write_reg(CFG_POLICY, CFG_W'(POL_DECAY));
        write_reg(CFG_DECAY_RATIO, CFG_W'(Q32_MAX));
        repeat (3) add_beat(EV_PROPOSAL, $urandom, {8'($urandom), 32'($urandom)});
        settle();

        write_reg(CFG_YIELD_ENABLE, CFG_W'(1'b0));
        add_beat(EV_PROPOSAL, $urandom, {8'($urandom), 32'($urandom)});
        add_beat(EV_PROPOSAL, $urandom, RATE_MAX);
        settle();

        write_reg(CFG_YIELD_ENABLE, CFG_W'(1'b1));
        write_reg(CFG_POLICY, CFG_W'(POL_NONE));
        add_beat(EV_PROPOSAL, 32'hFFFF_FFFF, '0);
        add_beat(EV_PROPOSAL, 32'h0, RATE_MAX);
        settle();

        write_reg(CFG_POLICY, CFG_W'(POL_FIXED));
        write_reg(CFG_FIXED_RATE, CFG_W'(RATE_MAX));
        add_beat(EV_PROPOSAL, $urandom, '0);
        settle();
        write_reg(CFG_FIXED_RATE, '0);
        add_beat(EV_PROPOSAL, $urandom, RATE_MAX);
        settle();

        run_phase(0, 0, 90);
        run_phase(88, 0, 90);
        run_phase(0, 88, 90);
        run_phase(35, 35, 90);

        // hold the output off while the input keeps offering beats
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        shuffle_config();
        hold_epoch <= hold_epoch + 1;
        add_random_beats(40);
        settle();

        // factors driven to zero
        write_reg(CFG_POLICY, CFG_W'(POL_STAIR));
        write_reg(CFG_STAIR_PERIOD, CFG_W'(16'd1));
        write_reg(CFG_STAIR_RATIO, '0);
        write_reg(CFG_STAIR_FLOOR, '0);
        write_reg(CFG_DECAY_RATIO, '0);
        repeat (3) add_beat(EV_PROPOSAL, $urandom, {8'($urandom), 32'($urandom)});
        settle();
        write_reg(CFG_POLICY, CFG_W'(POL_DECAY));
        repeat (2) add_beat(EV_PROPOSAL, $urandom, {8'($urandom), 32'($urandom)});
        settle();

        $display("tb: %0d beats in (%0d enter-yield), %0d results checked, %0d mismatches",
                 n_accepted, n_enters, n_results, n_errors);
        $display("tb: reduced under fixed %0d, stairway %0d, decay %0d; unused code %0d",
                 n_by_policy[POL_FIXED], n_by_policy[POL_STAIR], n_by_policy[POL_DECAY],
                 n_by_policy[POL_NONE]);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ yield_rate_reducer_top.f @@
+incdir+rtl/core
rtl/core/yrr_pkg.sv
rtl/core/yrr_in_if.sv
rtl/core/yrr_out_if.sv
rtl/core/yield_rate_reducer_top.sv
tb/sv/tb_yield_rate_reducer_top.sv
